FILE: rtl/brf_pkg.sv
package brf_pkg;

  // Built depth of the byte store unless the top level overrides it
  localparam int DEPTH_DEFAULT = 256;

  // Capacity register and the counts that follow from it
  localparam int CAP_W = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Operand width of the modulo unit: position plus offset
  localparam int MOD_W = 10;
  localparam int STEP_W = 4;

  // Operation codes
  localparam logic [2:0] OP_PUT       = 3'd0;
  localparam logic [2:0] OP_FORCE_PUT = 3'd1;
  localparam logic [2:0] OP_GET       = 3'd2;
  localparam logic [2:0] OP_PEEK      = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_in;
    logic [7:0] offset;
  } request_t;

  typedef struct packed {
    logic             ok;
    logic [7:0]       data_out;
    logic             overwrote;
    logic [CAP_W-1:0] fill_count;
    logic [CAP_W-1:0] free_slots;
    logic             is_empty;
    logic             is_full;
  } result_t;

  // Which position the modulo unit reduces, and where its remainder goes
  typedef enum logic [1:0] {
    MOD_WP,
    MOD_RP,
    MOD_PEEK
  } mod_sel_t;

  typedef struct packed {
    logic     load_req;
    logic     mem_wr;
    logic     mem_rd;
    logic     rd_peek;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     clear;
    logic     set_ok;
    logic     set_ovw;
    logic     mod_start;
    mod_sel_t mod_sel;
    logic     mod_wb;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       has_room;
    logic       not_empty;
    logic       is_full;
    logic       peek_in;
    logic       mod_done;
  } status_t;

endpackage

FILE: rtl/brf_mod.sv
module brf_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [brf_pkg::MOD_W-1:0] value,
  input  logic [brf_pkg::CAP_W-1:0] divisor,
  output logic                      done,
  output logic [brf_pkg::CAP_W-1:0] rem
);

  localparam int SH_W = brf_pkg::CAP_W + brf_pkg::MOD_W;

  logic [brf_pkg::MOD_W-1:0]  rem_q;
  logic [brf_pkg::STEP_W-1:0] step;
  logic                       running;
  logic [SH_W-1:0]            shifted;
  logic                       quick;

  // One subtraction covers values below twice the divisor
  assign quick   = {1'b0, value} < {1'b0, divisor, 1'b0};
  assign shifted = SH_W'(divisor) << step;
  assign rem     = rem_q[brf_pkg::CAP_W-1:0];

  // Restoring remainder, one quotient bit a cycle on the slow path
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (quick) begin
          rem_q   <= (value >= brf_pkg::MOD_W'(divisor))
                     ? value - brf_pkg::MOD_W'(divisor) : value;
          done    <= 1'b1;
          running <= 1'b0;
        end else begin
          rem_q   <= value;
          step    <= brf_pkg::STEP_W'(brf_pkg::MOD_W - 1);
          running <= 1'b1;
        end
      end else if (running) begin
        if (SH_W'(rem_q) >= shifted) begin
          rem_q <= rem_q - brf_pkg::MOD_W'(shifted);
        end
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/brf_datapath.sv
module brf_datapath #(
  parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  brf_pkg::request_t         request,
  input  logic                      cfg_we,
  input  logic [brf_pkg::CAP_W-1:0] cfg_wdata,
  input  brf_pkg::cmd_t             cmd,
  output brf_pkg::status_t          stat,
  output brf_pkg::result_t          result
);

  localparam int PW = $clog2(DEPTH);

  brf_pkg::request_t         req;
  logic [brf_pkg::CAP_W-1:0] cap;
  logic [brf_pkg::CAP_W-1:0] cap_eff;
  logic [brf_pkg::CAP_W-1:0] count;
  logic [PW-1:0]             rp;
  logic [PW-1:0]             wp;
  logic [PW-1:0]             peek_addr;
  logic [PW-1:0]             rd_addr;
  logic                      ok_flag;
  logic                      ovw_flag;
  logic [7:0]                rd_data;
  logic [7:0]                mem [DEPTH];
  brf_pkg::mod_sel_t         mod_tgt;
  logic [brf_pkg::MOD_W-1:0] mod_value;
  logic                      mod_done;
  logic [brf_pkg::CAP_W-1:0] mod_rem;
  logic                      reads_byte;

  // Clamp capacity into 1..DEPTH
  always_comb begin
    if (cap == '0) begin
      cap_eff = brf_pkg::CAP_W'(1);
    end else if (int'(cap) > DEPTH) begin
      cap_eff = brf_pkg::CAP_W'(DEPTH);
    end else begin
      cap_eff = cap;
    end
  end

  // Pick the position to wrap
  always_comb begin
    case (cmd.mod_sel)
      brf_pkg::MOD_WP:   mod_value = brf_pkg::MOD_W'(wp) + 1'b1;
      brf_pkg::MOD_RP:   mod_value = brf_pkg::MOD_W'(rp) + 1'b1;
      brf_pkg::MOD_PEEK: mod_value = brf_pkg::MOD_W'(rp) + brf_pkg::MOD_W'(req.offset);
      default:           mod_value = brf_pkg::MOD_W'(rp);
    endcase
  end

  brf_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mod_start),
    .value   (mod_value),
    .divisor (cap_eff),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // Report conditions to the controller
  always_comb begin
    stat.op        = req.operation;
    stat.has_room  = count < cap_eff;
    stat.not_empty = count != '0;
    stat.is_full   = count >= cap_eff;
    stat.peek_in   = brf_pkg::CAP_W'(req.offset) < count;
    stat.mod_done  = mod_done;
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= request;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= brf_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  // Remember where the remainder goes
  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      mod_tgt <= cmd.mod_sel;
    end
  end

  // Advance positions and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rp        <= '0;
      wp        <= '0;
      peek_addr <= '0;
      count     <= '0;
    end else if (cmd.clear) begin
      rp    <= '0;
      wp    <= '0;
      count <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end
      if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.mod_wb) begin
        case (mod_tgt)
          brf_pkg::MOD_WP:   wp        <= PW'(mod_rem);
          brf_pkg::MOD_RP:   rp        <= PW'(mod_rem);
          brf_pkg::MOD_PEEK: peek_addr <= PW'(mod_rem);
          default:           peek_addr <= PW'(mod_rem);
        endcase
      end
    end
  end

  // Outcome flags of the current request
  always_ff @(posedge clk) begin
    if (rst) begin
      ok_flag  <= 1'b0;
      ovw_flag <= 1'b0;
    end else if (cmd.load_req) begin
      ok_flag  <= 1'b0;
      ovw_flag <= 1'b0;
    end else begin
      if (cmd.set_ok) begin
        ok_flag <= 1'b1;
      end
      if (cmd.set_ovw) begin
        ovw_flag <= 1'b1;
      end
    end
  end

  // Byte store with registered read
  assign rd_addr = cmd.rd_peek ? peek_addr : rp;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wp] <= req.data_in;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Build the result from the settled state
  assign reads_byte = ok_flag &&
                      (req.operation == brf_pkg::OP_GET || req.operation == brf_pkg::OP_PEEK);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.ok         <= ok_flag;
      result.data_out   <= reads_byte ? rd_data : 8'd0;
      result.overwrote  <= ovw_flag;
      result.fill_count <= count;
      result.free_slots <= (count < cap_eff) ? cap_eff - count : '0;
      result.is_empty   <= count == '0;
      result.is_full    <= count >= cap_eff;
    end
  end

endmodule

FILE: rtl/brf_ctrl.sv
module brf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  brf_pkg::status_t stat,
  output brf_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MOD,
    S_READ,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   rp_pend;
  logic   rp_pend_next;

  // Decode state and status into datapath commands
  always_comb begin
    cmd          = '0;
    cmd.mod_sel  = brf_pkg::MOD_WP;
    state_next   = state;
    rp_pend_next = rp_pend;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_DONE;
        case (stat.op)
          brf_pkg::OP_PUT: begin
            if (stat.has_room) begin
              cmd.mem_wr    = 1'b1;
              cmd.cnt_inc   = 1'b1;
              cmd.set_ok    = 1'b1;
              cmd.mod_start = 1'b1;
              cmd.mod_sel   = brf_pkg::MOD_WP;
              state_next    = S_MOD;
            end
          end
          brf_pkg::OP_FORCE_PUT: begin
            cmd.mem_wr    = 1'b1;
            cmd.set_ok    = 1'b1;
            cmd.mod_start = 1'b1;
            cmd.mod_sel   = brf_pkg::MOD_WP;
            state_next    = S_MOD;
            if (stat.is_full) begin
              cmd.set_ovw  = 1'b1;
              rp_pend_next = 1'b1;
            end else begin
              cmd.cnt_inc = 1'b1;
            end
          end
          brf_pkg::OP_GET: begin
            if (stat.not_empty) begin
              cmd.mem_rd    = 1'b1;
              cmd.cnt_dec   = 1'b1;
              cmd.set_ok    = 1'b1;
              cmd.mod_start = 1'b1;
              cmd.mod_sel   = brf_pkg::MOD_RP;
              state_next    = S_MOD;
            end
          end
          brf_pkg::OP_PEEK: begin
            if (stat.peek_in) begin
              cmd.set_ok    = 1'b1;
              cmd.mod_start = 1'b1;
              cmd.mod_sel   = brf_pkg::MOD_PEEK;
              state_next    = S_MOD;
            end
          end
          brf_pkg::OP_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.set_ok = 1'b1;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_MOD: begin
        if (stat.mod_done) begin
          cmd.mod_wb = 1'b1;
          if (rp_pend) begin
            cmd.mod_start = 1'b1;
            cmd.mod_sel   = brf_pkg::MOD_RP;
            rp_pend_next  = 1'b0;
          end else if (stat.op == brf_pkg::OP_PEEK) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_peek = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, pending read advance, busy and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rp_pend <= 1'b0;
      busy    <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      rp_pend <= rp_pend_next;
      busy    <= state_next != S_IDLE;
      done    <= state == S_DONE;
    end
  end

endmodule

FILE: rtl/byte_ring_fifo_overwrite_peek.sv
// Byte FIFO on a circular store with forced overwrite and peek at an offset.
// Request channel: drive request and raise start; the request is taken at a
// clock edge where start is high and busy is low. busy stays high until the
// result is out. Result channel: done is high for exactly one cycle with the
// result on result; the receiver cannot stall it and must take it then.
// Configuration: cfg_we with cfg_wdata writes the capacity register; write it
// only while the block is idle and clear the buffer after changing it.
// From accept to done: a refused request, a clear or an unused code goes from
// evaluation straight to the result; put and get wrap one position in the
// shared modulo unit; peek wraps its address there, then does the registered
// read of the byte store; a forced put into a full buffer wraps the write and
// then the read position. busy falls in the done cycle, so a new request can be
// taken there, but none before the last result is out. A position left beyond a
// shrunken capacity takes the slower bit-serial path of the modulo unit.
// Reset empties the buffer, sets capacity to 256 (clamped to DEPTH) and
// leaves the byte store contents undefined.
module byte_ring_fifo_overwrite_peek #(
  parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  brf_pkg::request_t         request,
  output logic                      done,
  output brf_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [brf_pkg::CAP_W-1:0] cfg_wdata
);

  brf_pkg::cmd_t    cmd;
  brf_pkg::status_t stat;
  logic             busy_q;

  // Gate start so a request is only taken while idle
  brf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start & ~busy_q),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy_q),
    .done  (done)
  );

  assign busy = busy_q;

  brf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule
